### hw/rtl/cabf_pkg.sv
// shared constants for the coverage alpha blend frame core
package cabf_pkg;

  // default frame store depth
  localparam int unsigned FRAME_PIXELS_DEF = 1048576;

  // field and register widths
  localparam int unsigned POS_W    = 12;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned FULL_AW  = 26;   // y * width + x before range check
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // register reset values and addresses
  localparam logic [12:0] DIM_RESET = 13'd1024;
  localparam logic [2:0]  ADDR_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0]  ADDR_FRAME_HEIGHT = 3'd4;

  // item codes
  localparam logic CMD_BLEND = 1'b0;
  localparam logic CMD_READ  = 1'b1;
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  // blend arithmetic
  localparam int unsigned FULL_SQ    = 255 * 255;
  localparam int unsigned HALF_SQ    = 255 * 255 / 2;
  localparam logic [7:0]  CHAN_MAX   = 8'hFF;
  localparam int unsigned MIX_W      = 24;
  localparam int unsigned DIV_MUL    = 1032;   // floor(2^26 / 65025)
  localparam int unsigned DIV_SHIFT  = 26;
  localparam int unsigned DIV_PROD_W = 35;
  localparam int unsigned QUOT_W     = 9;
  localparam int unsigned REM_W      = 25;

  // straight alpha conversion
  localparam int unsigned RECIP_NUM  = 255 << 16;
  localparam int unsigned INV_W      = 24;
  localparam int unsigned ROUND_HALF = 1 << 15;
  localparam int unsigned UNPM_W     = 32;

endpackage

### hw/rtl/cabf_ram.sv
// generic single port ram with registered read
module cabf_ram #(
  parameter  int unsigned DATA_W = 32,
  parameter  int unsigned DEPTH  = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/coverage_alpha_blend_frame_core.sv
// top level: premultiplied rgba8 frame store with blend and straight-alpha read
//
// Input channel (in_valid / in_stall) carries one item: cmd selects a blend of
// coverage-weighted color into the pixel at (pos_x, pos_y), or a read of that
// pixel converted to straight alpha. Every item gives one result on the output
// channel (out_valid / out_stall): the color for reads, zeros for blends, and
// status 1 when the position lies outside the frame (the item is then ignored).
// Items are handled one at a time around a single port frame memory: a blend
// steps through the states mul, addr, rd, wait, calc1, calc2 and done, a read
// skips calc2, and an outside position goes from rd straight to done. The next
// item is taken once the previous one has left the datapath; a result sits in
// the output register, so a stalled receiver only holds the block when a second
// result is ready before the first was taken.
// After reset the frame memory is cleared one pixel per cycle, all FRAME_PIXELS
// entries, with in_stall held high; register writes are taken during that time.
// frame_width (byte address 0) and frame_height (byte address 4) reset to 1024;
// the user must write them via the apb port while the block is idle (unchecked).
module coverage_alpha_blend_frame_core #(
  parameter int unsigned FRAME_PIXELS = cabf_pkg::FRAME_PIXELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // apb register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cabf_pkg::PADDR_W-1:0]  paddr,
  input  logic [cabf_pkg::PDATA_W-1:0]  pwdata,
  output logic [cabf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [cabf_pkg::POS_W-1:0]    in_pos_x,
  input  logic [cabf_pkg::POS_W-1:0]    in_pos_y,
  input  logic [cabf_pkg::CHAN_W-1:0]   in_coverage,
  input  logic [cabf_pkg::COLOR_W-1:0]  in_pixel_color,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cabf_pkg::CHAN_W-1:0]   out_red_out,
  output logic [cabf_pkg::CHAN_W-1:0]   out_green_out,
  output logic [cabf_pkg::CHAN_W-1:0]   out_blue_out,
  output logic [cabf_pkg::CHAN_W-1:0]   out_alpha_out,
  output logic                          out_status
);

  localparam int unsigned AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int unsigned CW = cabf_pkg::CHAN_W;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_ADDR  = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_WAIT  = 4'd5;
  localparam logic [3:0] ST_CALC1 = 4'd6;
  localparam logic [3:0] ST_CALC2 = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  typedef logic [3:0][CW-1:0] chan4_t;

  // registers
  logic [3:0]                        state_r, state_nxt;
  logic [AW-1:0]                     clr_cnt_r;
  logic [cabf_pkg::DIM_W-1:0]        width_r, height_r;
  logic                              cmd_r;
  logic [cabf_pkg::POS_W-1:0]        x_r, y_r;
  logic [CW-1:0]                     cov_r;
  logic [cabf_pkg::COLOR_W-1:0]      color_r;
  logic [cabf_pkg::FULL_AW-1:0]      prod_r;
  logic [cabf_pkg::FULL_AW-1:0]      addr_r;
  logic                              oob_r;
  logic [cabf_pkg::PIXEL_W-1:0]      px_r;
  logic [15:0]                       k_r;
  logic [cabf_pkg::INV_W-1:0]        inv_r;
  logic [3:0][cabf_pkg::MIX_W-1:0]   mix_r;
  logic [3:0][cabf_pkg::UNPM_W-1:0]  unpm_r;
  logic [3:0][cabf_pkg::QUOT_W-1:0]  quot_r;
  logic                              out_valid_r;
  chan4_t                            out_chan_r;
  logic                              out_status_r;

  // combinational
  logic                              in_xfer, done_go;
  logic [cabf_pkg::FULL_AW-1:0]      addr_full;
  logic                              oob_nxt;
  logic [CW-1:0]                     alpha_old;
  chan4_t                            chan_old, chan_src;
  chan4_t                            blend_new, read_new;
  logic [3:0][cabf_pkg::MIX_W-1:0]   mix_nxt;
  logic [3:0][cabf_pkg::UNPM_W-1:0]  unpm_nxt;
  logic [3:0][cabf_pkg::QUOT_W-1:0]  quot_nxt;
  logic [cabf_pkg::INV_W-1:0]        inv_tbl [256];
  logic                              ram_en, ram_we;
  logic [AW-1:0]                     ram_addr;
  logic [cabf_pkg::PIXEL_W-1:0]      ram_wdata, ram_rdata;
  logic                              cfg_wr;

  // reciprocal table for straight alpha, entry a holds (255 << 16) / a + 1
  assign inv_tbl[0] = '0;
  for (genvar Idx = 1; Idx < 256; Idx++) begin : g_inv
    localparam int unsigned InvVal = cabf_pkg::RECIP_NUM / Idx + 1;
    assign inv_tbl[Idx] = cabf_pkg::INV_W'(InvVal);
  end

  cabf_ram #(
    .DATA_W (cabf_pkg::PIXEL_W),
    .DEPTH  (FRAME_PIXELS)
  ) u_frame_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr)
      cabf_pkg::ADDR_FRAME_WIDTH:  prdata = cabf_pkg::PDATA_W'(width_r);
      cabf_pkg::ADDR_FRAME_HEIGHT: prdata = cabf_pkg::PDATA_W'(height_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cabf_pkg::DIM_RESET;
      height_r <= cabf_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      if (paddr == cabf_pkg::ADDR_FRAME_WIDTH) begin
        width_r <= pwdata[cabf_pkg::DIM_W-1:0];
      end
      if (paddr == cabf_pkg::ADDR_FRAME_HEIGHT) begin
        height_r <= pwdata[cabf_pkg::DIM_W-1:0];
      end
    end
  end

  // handshake
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid & ~in_stall;
  assign done_go   = (state_r == ST_DONE) & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;

  // address and frame check
  assign addr_full = prod_r + cabf_pkg::FULL_AW'(x_r);
  assign oob_nxt   = ({1'b0, x_r} >= width_r) || ({1'b0, y_r} >= height_r) ||
                     (addr_full >= cabf_pkg::FULL_AW'(FRAME_PIXELS));

  // channel views: stored order red, green, blue, alpha from the low byte
  assign alpha_old = ram_rdata[31:24];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      chan_old[i] = px_r[CW*i +: CW];
    end
    chan_src[0] = color_r[31:24];
    chan_src[1] = color_r[23:16];
    chan_src[2] = color_r[15:8];
    chan_src[3] = cabf_pkg::CHAN_MAX;
  end

  // blend: k*c + (65025-k)*old + 32512, then divide by 65025
  always_comb begin
    logic [cabf_pkg::MIX_W-1:0]      kc, ko;
    logic [cabf_pkg::DIV_PROD_W-1:0] dprod;
    logic [cabf_pkg::REM_W-1:0]      qm, rem;
    logic [cabf_pkg::QUOT_W-1:0]     q;
    for (int i = 0; i < 4; i++) begin
      kc = cabf_pkg::MIX_W'(k_r) * cabf_pkg::MIX_W'(chan_src[i]);
      ko = cabf_pkg::MIX_W'(16'(cabf_pkg::FULL_SQ) - k_r) * cabf_pkg::MIX_W'(chan_old[i]);
      mix_nxt[i] = kc + ko + cabf_pkg::MIX_W'(cabf_pkg::HALF_SQ);
      // reciprocal estimate is exact or one low
      dprod = cabf_pkg::DIV_PROD_W'(mix_r[i]) * cabf_pkg::DIV_PROD_W'(cabf_pkg::DIV_MUL);
      quot_nxt[i] = cabf_pkg::QUOT_W'(dprod >> cabf_pkg::DIV_SHIFT);
      qm  = cabf_pkg::REM_W'(quot_r[i]) * cabf_pkg::REM_W'(cabf_pkg::FULL_SQ);
      rem = cabf_pkg::REM_W'(mix_r[i]) - qm;
      q   = quot_r[i];
      if (rem >= cabf_pkg::REM_W'(cabf_pkg::FULL_SQ)) begin
        q = q + 1'b1;
      end
      blend_new[i] = q[CW-1:0];
    end
  end

  // read: (c*inv + 32768) >> 16, alpha passes; zero alpha returns the pixel
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      unpm_nxt[i] = cabf_pkg::UNPM_W'(chan_old[i]) * cabf_pkg::UNPM_W'(inv_r) +
                    cabf_pkg::UNPM_W'(cabf_pkg::ROUND_HALF);
    end
    for (int i = 0; i < 3; i++) begin
      read_new[i] = (chan_old[3] == '0) ? chan_old[i] : unpm_r[i][23:16];
    end
    read_new[3] = chan_old[3];
  end

  // memory port
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_r[AW-1:0];
    ram_wdata = blend_new;
    case (state_r)
      ST_CLR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_r;
        ram_wdata = '0;
      end
      ST_RD: begin
        ram_en = ~oob_r;
      end
      ST_DONE: begin
        ram_en = done_go & ~oob_r & (cmd_r == cabf_pkg::CMD_BLEND);
        ram_we = 1'b1;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:   if (clr_cnt_r == AW'(FRAME_PIXELS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_xfer) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_RD;
      ST_RD:    state_nxt = oob_r ? ST_DONE : ST_WAIT;
      ST_WAIT:  state_nxt = ST_CALC1;
      ST_CALC1: state_nxt = (cmd_r == cabf_pkg::CMD_BLEND) ? ST_CALC2 : ST_DONE;
      ST_CALC2: state_nxt = ST_DONE;
      ST_DONE:  if (done_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (~out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= in_cmd;
      x_r     <= in_pos_x;
      y_r     <= in_pos_y;
      cov_r   <= in_coverage;
      color_r <= in_pixel_color;
    end
    if (state_r == ST_MUL) begin
      prod_r <= cabf_pkg::FULL_AW'(y_r) * cabf_pkg::FULL_AW'(width_r);
    end
    if (state_r == ST_ADDR) begin
      addr_r <= addr_full;
      oob_r  <= oob_nxt;
    end
    if (state_r == ST_WAIT) begin
      px_r  <= ram_rdata;
      k_r   <= 16'(cov_r) * 16'(cabf_pkg::CHAN_MAX - color_r[7:0]);
      inv_r <= inv_tbl[alpha_old];
    end
    if (state_r == ST_CALC1) begin
      mix_r  <= mix_nxt;
      unpm_r <= unpm_nxt;
    end
    if (state_r == ST_CALC2) begin
      quot_r <= quot_nxt;
    end
    if (done_go) begin
      if (oob_r || cmd_r == cabf_pkg::CMD_BLEND) begin
        out_chan_r <= '0;
      end else begin
        out_chan_r <= read_new;
      end
      out_status_r <= oob_r ? cabf_pkg::STATUS_OUTSIDE : cabf_pkg::STATUS_DONE;
    end
  end

  assign out_red_out   = out_chan_r[0];
  assign out_green_out = out_chan_r[1];
  assign out_blue_out  = out_chan_r[2];
  assign out_alpha_out = out_chan_r[3];
  assign out_status    = out_status_r;

endmodule
